### rtl/gfl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the gamma fit block.
// No dependencies; every other file imports this package.
package gfl_pkg;

    localparam int CODE_W    = 16;   // width of a code word and of a register
    localparam int CODE_BITS = 16;   // significant bits of a code
    localparam int E_BITS    = 4;    // integer part of a log2 of a 16-bit value
    localparam int MANT_BITS = 30;   // mantissa fraction bits in the log unit
    localparam int QDEPTH    = 4;    // entries in the front queue
    localparam int QPTR_W    = 2;

    localparam logic [23:0] GAMMA_MAX = 24'h7FFFFF;
    localparam logic [23:0] GAMMA_MIN = 24'h800000;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_DEN  = 2'd1,
        ST_BELOW_MIN = 2'd2,
        ST_BAD_RANGE = 2'd3
    } gfl_status_t;

    typedef enum logic [1:0] {
        REG_IN_MIN  = 2'd0,
        REG_IN_MAX  = 2'd1,
        REG_OUT_MIN = 2'd2,
        REG_OUT_MAX = 2'd3
    } gfl_reg_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_DECIDE,
        BK_LSTART,
        BK_LWAIT,
        BK_MUL,
        BK_ACC,
        BK_FIN,
        BK_DSTART,
        BK_DWAIT
    } gfl_bstate_t;

    typedef struct packed {
        logic [CODE_W-1:0] in_min;
        logic [CODE_W-1:0] in_max;
        logic [CODE_W-1:0] out_min;
        logic [CODE_W-1:0] out_max;
    } gfl_cfg_t;

    typedef struct packed {
        logic              use_pt;    // point enters the denominator sum
        logic              has_y;     // point also enters the numerator sum
        logic              below;     // a sample fell below its minimum
        logic              range_ok;  // both ranges valid when the word came in
        logic              last;
        logic [CODE_W-1:0] dx;
        logic [CODE_W-1:0] dy;
    } gfl_item_t;

endpackage

### rtl/gfl_front.sv
`timescale 1ns / 1ps
// Front end: masks and classifies each incoming word and queues it.
// Depends on gfl_pkg.
module gfl_front
    import gfl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [CODE_W-1:0] x_code,
    input  logic [CODE_W-1:0] y_code,
    input  logic              last,
    input  gfl_cfg_t          cfg,
    input  logic              q_pop,
    output logic              q_empty,
    output gfl_item_t         q_item,
    output logic [CODE_W-1:0] in_rng,
    output logic [CODE_W-1:0] out_rng
);

    localparam logic [CODE_W-1:0] CODE_MASK =
        (CODE_BITS >= CODE_W) ? {CODE_W{1'b1}} : CODE_W'((32'd1 << CODE_BITS) - 32'd1);

    logic [CODE_W-1:0] xm, ym, imn, imx, omn, omx;
    logic              range_ok;
    gfl_item_t         item;

    gfl_item_t         q_mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              push_ok, pop_ok;

    always_comb
    begin
        xm  = x_code & CODE_MASK;
        ym  = y_code & CODE_MASK;
        imn = cfg.in_min & CODE_MASK;
        imx = cfg.in_max & CODE_MASK;
        omn = cfg.out_min & CODE_MASK;
        omx = cfg.out_max & CODE_MASK;
        range_ok      = (imx > imn) && (omx > omn);
        item.range_ok = range_ok;
        item.below    = range_ok && ((xm < imn) || ((xm > imn) && (ym < omn)));
        item.use_pt   = range_ok && (xm > imn) && (ym >= omn);
        item.has_y    = ym > omn;
        item.last     = last;
        item.dx       = xm - imn;
        item.dy       = ym - omn;
        in_rng        = imx - imn;
        out_rng       = omx - omn;
    end

    assign full    = count_reg == (QPTR_W+1)'(QDEPTH);
    assign q_empty = count_reg == '0;
    assign push_ok = push && !full;
    assign pop_ok  = q_pop && !q_empty;
    assign q_item  = q_mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg + (QPTR_W+1)'(push_ok) - (QPTR_W+1)'(pop_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push_ok)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop_ok)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
            q_mem[wr_ptr_reg] <= item;
    end

endmodule

### rtl/gfl_log2.sv
`timescale 1ns / 1ps
// Iterative base-2 logarithm: one fraction bit per cycle by repeated squaring.
// Depends on gfl_pkg.
module gfl_log2
    import gfl_pkg::*;
#(
    parameter int LOG_FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [CODE_W-1:0]                 operand,
    output logic                              done,
    output logic [E_BITS+LOG_FRAC_BITS-1:0]   result
);

    localparam int CNT_W = $clog2(LOG_FRAC_BITS + 1);

    logic [E_BITS-1:0]        e_in, e_reg;
    logic [4:0]               sh;
    logic [MANT_BITS:0]       m_init, m_reg, m_step;
    logic [2*MANT_BITS+1:0]   sq;
    logic                     bit_one;
    logic [LOG_FRAC_BITS-1:0] frac_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     busy_reg, done_reg;

    // Leading-one position; the highest set bit wins.
    always_comb
    begin
        e_in = '0;
        for (int i = 0; i < CODE_W; i++)
        begin
            if (operand[i])
                e_in = E_BITS'(i);
        end
        sh     = 5'(MANT_BITS) - {1'b0, e_in};
        m_init = {{(MANT_BITS+1-CODE_W){1'b0}}, operand} << sh;
    end

    always_comb
    begin
        sq      = m_reg * m_reg;
        bit_one = sq[2*MANT_BITS+1];
        m_step  = bit_one ? sq[2*MANT_BITS+1:MANT_BITS+1] : sq[2*MANT_BITS:MANT_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && cnt_reg == CNT_W'(LOG_FRAC_BITS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            m_reg    <= m_init;
            e_reg    <= e_in;
            frac_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            m_reg    <= m_step;
            frac_reg <= {frac_reg[LOG_FRAC_BITS-2:0], bit_one};
            cnt_reg  <= cnt_reg + 1'b1;
        end
    end

    assign done   = done_reg;
    assign result = {e_reg, frac_reg};

endmodule

### rtl/gfl_div.sv
`timescale 1ns / 1ps
// Restoring divider for the final ratio, rounded and saturated to signed Q8.16.
// Depends on gfl_pkg.
module gfl_div
    import gfl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic        done,
    output logic [23:0] quot
);

    logic [63:0] a_mag;
    logic        num_neg, sat;
    logic [72:0] r_reg, d_reg, r_sub, r_next;
    logic        ge;
    logic [24:0] bits_reg;
    logic [4:0]  cnt_reg;
    logic        neg_reg, busy_reg, rnd_reg, done_reg;
    logic [23:0] quot_reg;
    logic [25:0] val26;
    logic [24:0] val;

    always_comb
    begin
        num_neg = num[63];
        a_mag   = num_neg ? (~num + 64'd1) : num;
        sat     = {9'b0, a_mag} >= {1'b0, den, 8'b0};
        ge      = r_reg >= d_reg;
        r_sub   = ge ? (r_reg - d_reg) : r_reg;
        r_next  = {r_sub[71:0], 1'b0};
        val26   = {1'b0, bits_reg} + 26'd1;
        val     = val26[25:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rnd_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= !sat;
                done_reg <= sat;
            end
            else if (busy_reg && cnt_reg == 5'd24)
            begin
                busy_reg <= 1'b0;
                rnd_reg  <= 1'b1;
            end
            else if (rnd_reg)
            begin
                rnd_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg  <= num_neg;
            quot_reg <= num_neg ? GAMMA_MIN : GAMMA_MAX;
            r_reg    <= {9'b0, a_mag};
            d_reg    <= {2'b0, den, 7'b0};
            bits_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            r_reg    <= r_next;
            bits_reg <= {bits_reg[23:0], ge};
            cnt_reg  <= cnt_reg + 5'd1;
        end
        else if (rnd_reg)
        begin
            if (neg_reg)
                quot_reg <= (val > 25'd8388608) ? GAMMA_MIN : 24'(~val + 25'd1);
            else
                quot_reg <= (val > 25'd8388607) ? GAMMA_MAX : val[23:0];
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

### rtl/gfl_back.sv
`timescale 1ns / 1ps
// Back end: takes queued words, forms log ratios, accumulates the sums and
// produces the result word. Depends on gfl_pkg, gfl_log2 and gfl_div.
module gfl_back
    import gfl_pkg::*;
#(
    parameter int MAX_POINTS    = 4096,
    parameter int LOG_FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  gfl_item_t         q_item,
    output logic              q_pop,
    input  logic [CODE_W-1:0] in_rng,
    input  logic [CODE_W-1:0] out_rng,
    input  logic              pop,
    output logic              empty,
    output logic [23:0]       gamma_q16,
    output logic [1:0]        status,
    output logic [12:0]       points_used
);

    localparam int LU_W  = E_BITS + LOG_FRAC_BITS;
    localparam int LOG_W = LU_W + 1;
    localparam int P_W   = 2 * LOG_W;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    gfl_bstate_t state_reg, state_next;
    gfl_item_t   item_reg;
    logic [1:0]  idx_reg;
    logic        mxy_reg;
    logic signed [LOG_W-1:0] lx_reg, ly_reg, lr, mul_b;
    logic signed [P_W-1:0]   prod_reg, prod_sh;
    logic [63:0]             prod_ext;
    logic [63:0]             sum_xx_reg, sum_xy_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    below_reg;
    logic                    out_valid_reg;
    logic [23:0]             gamma_reg;
    gfl_status_t             status_reg, st;
    logic [12:0]             used_reg;
    logic [CNT_W+12:0]       cnt_wide;

    logic              log_start, log_done, div_start, div_done, load_out;
    logic [CODE_W-1:0] log_opnd;
    logic [LU_W-1:0]   log_res;
    logic [23:0]       div_q;

    gfl_log2 #(.LOG_FRAC_BITS(LOG_FRAC_BITS)) u_log2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (log_start),
        .operand (log_opnd),
        .done    (log_done),
        .result  (log_res)
    );

    gfl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (sum_xy_reg),
        .den   (sum_xx_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    always_comb
    begin
        case (idx_reg)
            2'd0:    log_opnd = item_reg.dx;
            2'd1:    log_opnd = in_rng;
            2'd2:    log_opnd = item_reg.dy;
            default: log_opnd = out_rng;
        endcase
        lr       = signed'({1'b0, log_res});
        mul_b    = mxy_reg ? ly_reg : lx_reg;
        prod_sh  = prod_reg >>> LOG_FRAC_BITS;
        prod_ext = {{(64-P_W){prod_sh[P_W-1]}}, prod_sh};
        cnt_wide = {13'b0, cnt_reg};
        if (!item_reg.range_ok)
            st = ST_BAD_RANGE;
        else if (below_reg)
            st = ST_BELOW_MIN;
        else if (sum_xx_reg == 64'd0)
            st = ST_ZERO_DEN;
        else
            st = ST_OK;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
                if (!q_empty)
                    state_next = BK_DECIDE;
            BK_DECIDE:
                if (item_reg.use_pt && cnt_reg < CNT_W'(MAX_POINTS))
                    state_next = BK_LSTART;
                else
                    state_next = BK_FIN;
            BK_LSTART:
                state_next = BK_LWAIT;
            BK_LWAIT:
                if (log_done)
                begin
                    if (idx_reg == 2'd3 || (idx_reg == 2'd1 && !item_reg.has_y))
                        state_next = BK_MUL;
                    else
                        state_next = BK_LSTART;
                end
            BK_MUL:
                state_next = BK_ACC;
            BK_ACC:
                if (!mxy_reg && item_reg.has_y)
                    state_next = BK_MUL;
                else
                    state_next = BK_FIN;
            BK_FIN:
                if (!item_reg.last)
                    state_next = BK_IDLE;
                else if (out_valid_reg)
                    state_next = BK_FIN;
                else if (st != ST_OK)
                    state_next = BK_IDLE;
                else
                    state_next = BK_DSTART;
            BK_DSTART:
                state_next = BK_DWAIT;
            BK_DWAIT:
                if (div_done)
                    state_next = BK_IDLE;
            default:
                state_next = BK_IDLE;
        endcase
    end

    // Control outputs.
    always_comb
    begin
        q_pop     = 1'b0;
        log_start = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            BK_IDLE:   q_pop     = !q_empty;
            BK_LSTART: log_start = 1'b1;
            BK_DSTART: div_start = 1'b1;
            BK_FIN:    load_out  = item_reg.last && !out_valid_reg && (st != ST_OK);
            BK_DWAIT:  load_out  = div_done;
            default:   q_pop     = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            sum_xx_reg    <= '0;
            sum_xy_reg    <= '0;
            cnt_reg       <= '0;
            below_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_DECIDE && item_reg.below)
                below_reg <= 1'b1;
            if (state_reg == BK_ACC)
            begin
                if (!mxy_reg)
                begin
                    sum_xx_reg <= sum_xx_reg + prod_ext;
                    cnt_reg    <= cnt_reg + 1'b1;
                end
                else
                    sum_xy_reg <= sum_xy_reg + prod_ext;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                sum_xx_reg    <= '0;
                sum_xy_reg    <= '0;
                cnt_reg       <= '0;
                below_reg     <= 1'b0;
            end
            else if (pop && out_valid_reg)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            item_reg <= q_item;
        if (state_reg == BK_DECIDE)
        begin
            idx_reg <= 2'd0;
            mxy_reg <= 1'b0;
        end
        if (state_reg == BK_LWAIT && log_done)
        begin
            case (idx_reg)
                2'd0:    lx_reg <= lr;
                2'd1:    lx_reg <= lx_reg - lr;
                2'd2:    ly_reg <= lr;
                default: ly_reg <= ly_reg - lr;
            endcase
            idx_reg <= idx_reg + 2'd1;
        end
        if (state_reg == BK_MUL)
            prod_reg <= lx_reg * mul_b;
        if (state_reg == BK_ACC)
            mxy_reg <= 1'b1;
        if (load_out)
        begin
            gamma_reg  <= (state_reg == BK_DWAIT) ? div_q : 24'd0;
            status_reg <= (state_reg == BK_DWAIT) ? ST_OK : st;
            used_reg   <= cnt_wide[12:0];
        end
    end

    assign empty       = !out_valid_reg;
    assign gamma_q16   = gamma_reg;
    assign status      = status_reg;
    assign points_used = used_reg;

endmodule

### rtl/gamma_fit_log_least_squares.sv
`timescale 1ns / 1ps
// Top level of the log-log least-squares gamma fit, with its register port.
// Depends on gfl_pkg, gfl_front and gfl_back.

// The block fits an exponent to a set of (input, output) code pairs. Words are
// pushed one per cycle into a four-entry queue as long as full is low; the
// front end classifies each word against the configured ranges at that moment.
// The back end then runs, for a point that enters both sums, four base-2
// logarithms one after another on a shared iterative log unit (one squaring
// multiplier), after the queue handoff, and then forms the two products and
// accumulates them. A point whose output sits at its minimum needs only two
// logarithms, and a skipped point needs none. The word marked last
// additionally runs the restoring divider when its set has no error
// status, and then places one result word on the output side, where it
// waits until popped while the front keeps accepting words until its queue
// is full. Ranges may only be written while the block is idle. Results are
// held in a single output register: gamma_q16 is signed Q8.16 rounded half
// away from zero, status reports a bad range, a sample below its minimum or a
// zero denominator in that priority, and points_used counts the points in the
// fit.
module gamma_fit_log_least_squares
    import gfl_pkg::*;
#(
    parameter int MAX_POINTS    = 4096,
    parameter int LOG_FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // input words
    input  logic        push,
    output logic        full,
    input  logic [15:0] x_code,
    input  logic [15:0] y_code,
    input  logic        last,
    // result words
    output logic        empty,
    input  logic        pop,
    output logic [23:0] gamma_q16,
    output logic [1:0]  status,
    output logic [12:0] points_used,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    gfl_cfg_t          cfg_reg;
    logic              wr_en;
    logic              q_pop, q_empty;
    gfl_item_t         q_item;
    logic [CODE_W-1:0] in_rng, out_rng;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Configuration registers, one 16-bit range end per 32-bit slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.in_min  <= 16'h0000;
            cfg_reg.in_max  <= 16'hFFFF;
            cfg_reg.out_min <= 16'h0000;
            cfg_reg.out_max <= 16'hFFFF;
        end
        else if (wr_en)
        begin
            case (gfl_reg_t'(paddr[3:2]))
                REG_IN_MIN:  cfg_reg.in_min  <= pwdata[15:0];
                REG_IN_MAX:  cfg_reg.in_max  <= pwdata[15:0];
                REG_OUT_MIN: cfg_reg.out_min <= pwdata[15:0];
                REG_OUT_MAX: cfg_reg.out_max <= pwdata[15:0];
                default:     cfg_reg.in_min  <= cfg_reg.in_min;
            endcase
        end
    end

    always_comb
    begin
        case (gfl_reg_t'(paddr[3:2]))
            REG_IN_MIN:  prdata = {16'b0, cfg_reg.in_min};
            REG_IN_MAX:  prdata = {16'b0, cfg_reg.in_max};
            REG_OUT_MIN: prdata = {16'b0, cfg_reg.out_min};
            REG_OUT_MAX: prdata = {16'b0, cfg_reg.out_max};
            default:     prdata = 32'b0;
        endcase
    end

    gfl_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .x_code  (x_code),
        .y_code  (y_code),
        .last    (last),
        .cfg     (cfg_reg),
        .q_pop   (q_pop),
        .q_empty (q_empty),
        .q_item  (q_item),
        .in_rng  (in_rng),
        .out_rng (out_rng)
    );

    gfl_back #(
        .MAX_POINTS    (MAX_POINTS),
        .LOG_FRAC_BITS (LOG_FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .in_rng      (in_rng),
        .out_rng     (out_rng),
        .pop         (pop),
        .empty       (empty),
        .gamma_q16   (gamma_q16),
        .status      (status),
        .points_used (points_used)
    );

`ifndef NO_ASSERTIONS
    // A failed fit never reports an exponent.
    a_gamma_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != ST_OK) |-> gamma_q16 == 24'd0)
        else $error("nonzero gamma with error status");

    // The point count never exceeds the configured capacity.
    a_points_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> {19'b0, points_used} <= 32'(MAX_POINTS))
        else $error("points_used above MAX_POINTS");
`endif

endmodule

### tb/sv/gamma_fit_log_least_squares_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the log-log least-squares gamma fit block.
// Depends on gfl_pkg and the RTL of gamma_fit_log_least_squares.
import gfl_pkg::*;

// Expected contents of one result word.
typedef struct {
    logic [23:0] gamma;
    gfl_status_t st;
    logic [12:0] used;
} gamma_word_t;

// Scoreboard: holds a private copy of the ranges and the running sums, predicts
// the result word caused by each accepted input word marked last, and checks
// results in order against those predictions.
class gamma_fit_board;
    logic [15:0]  in_lo = 16'd0, in_hi = 16'hFFFF, out_lo = 16'd0, out_hi = 16'hFFFF;
    longint       acc_xx, acc_xy;
    int           npts;
    bit           below_flag;
    gamma_word_t  fits_due[$];
    int           errors;

    function void clear_set();
        acc_xx = 0;
        acc_xy = 0;
        npts = 0;
        below_flag = 0;
    endfunction

    // Base-2 log of v >= 1 with 16 fraction bits, mantissa squared in Q1.30.
    function automatic longint log2_q16(int unsigned v);
        int e;
        longint unsigned m;
        longint f;
        e = 0;
        f = 0;
        while (e < 31 && (v >> (e + 1)) != 0)
            e++;
        m = longint'(v) << (30 - e);
        for (int i = 0; i < 16; i++)
        begin
            m = (m * m) >> 30;
            f = f << 1;
            if (m >= (64'd2 << 30))
            begin
                f = f | 1;
                m = m >> 1;
            end
        end
        return (longint'(e) << 16) + f;
    endfunction

    // Rounded n * 2^16 / d, saturated to 24 signed bits.
    function automatic logic [23:0] ratio_q16(longint n, longint d);
        bit neg;
        longint unsigned a, q, r, fr, val;
        neg = n < 0;
        a = neg ? -n : n;
        q = a / d;
        r = a % d;
        fr = 0;
        if (q >= 256)
            return neg ? GAMMA_MIN : GAMMA_MAX;
        for (int i = 0; i < 17; i++)
        begin
            r = r << 1;
            fr = fr << 1;
            if (r >= d)
            begin
                r = r - d;
                fr = fr | 1;
            end
        end
        val = ((q << 17) | fr);
        val = (val + 1) >> 1;
        if (neg)
            return (val > 64'd8388608) ? GAMMA_MIN : 24'(-longint'(val));
        return (val > 64'd8388607) ? GAMMA_MAX : 24'(val);
    endfunction

    function void note_word(logic [15:0] x, logic [15:0] y, logic lst);
        bit ok;
        longint lx, ly;
        gamma_word_t w;
        ok = in_hi > in_lo && out_hi > out_lo;
        if (ok)
        begin
            if (x < in_lo)
                below_flag = 1;
            else if (x > in_lo)
            begin
                if (y < out_lo)
                    below_flag = 1;
                else if (npts < 4096)
                begin
                    lx = log2_q16(x - in_lo) - log2_q16(in_hi - in_lo);
                    acc_xx += (lx * lx) >>> 16;
                    npts++;
                    if (y > out_lo)
                    begin
                        ly = log2_q16(y - out_lo) - log2_q16(out_hi - out_lo);
                        acc_xy += (lx * ly) >>> 16;
                    end
                end
            end
        end
        if (!lst)
            return;
        w.gamma = 24'd0;
        if (!ok)
            w.st = ST_BAD_RANGE;
        else if (below_flag)
            w.st = ST_BELOW_MIN;
        else if (acc_xx == 0)
            w.st = ST_ZERO_DEN;
        else
            w.st = ST_OK;
        if (w.st == ST_OK)
            w.gamma = ratio_q16(acc_xy, acc_xx);
        w.used = 13'(npts);
        fits_due.push_back(w);
        clear_set();
    endfunction

    function void check_word(logic [23:0] g, logic [1:0] s, logic [12:0] u);
        gamma_word_t w;
        if (fits_due.size() == 0)
        begin
            $display("%0t: result word with none expected (gamma %h status %0d used %0d)",
                     $time, g, s, u);
            errors++;
            return;
        end
        w = fits_due.pop_front();
        if (g !== w.gamma)
        begin
            $display("%0t: gamma_q16 expected %h actual %h", $time, w.gamma, g);
            errors++;
        end
        if (s !== w.st)
        begin
            $display("%0t: status expected %0d actual %0d", $time, w.st, s);
            errors++;
        end
        if (u !== w.used)
        begin
            $display("%0t: points_used expected %0d actual %0d", $time, w.used, u);
            errors++;
        end
    endfunction
endclass

module gamma_fit_log_least_squares_test;

    localparam int STALL_LIMIT = 6000;   // cycles with no word moving on either side
    localparam int HOLD_LEN    = 400;    // long receiver hold-off

    logic        clk, rst_n;
    logic        push, full, last, empty, pop;
    logic [15:0] x_code, y_code;
    logic [23:0] gamma_q16;
    logic [1:0]  status;
    logic [12:0] points_used;
    logic        psel, penable, pwrite, pready;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;

    gamma_fit_board board;
    int words_in, fits_out, reg_writes, idle_cycles;
    int burst_left;
    bit steady;            // when set, the sender does not idle between words
    int hold_req, hold_seen, hold_left;
    logic [15:0] pop_pattern;
    int pop_phase;

    gamma_fit_log_least_squares u_top (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full), .x_code(x_code), .y_code(y_code), .last(last),
        .empty(empty), .pop(pop), .gamma_q16(gamma_q16), .status(status),
        .points_used(points_used),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver: checks every popped word, then decides on pop for the next
    // edge. It follows a random 16-bit stall pattern that is periodically
    // redrawn (sometimes to all ones), and it honors a requested long hold-off.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                board.check_word(gamma_q16, status, points_used);
                fits_out++;
            end
            if (hold_seen != hold_req)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_LEN;
            end
            pop_phase++;
            if (pop_phase % 256 == 0)
                pop_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= pop_pattern[pop_phase % 16];
        end
    end

    // Watchdog: the run is stuck if no word moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("gamma_fit_log_least_squares_test NOT OK");
                $finish;
            end
        end
    end

    // Offers one word and waits until it is taken. push stays high afterward
    // unless the burst is over, in which case the sender idles for a while.
    task automatic send_word(logic [15:0] x, logic [15:0] y, logic lst);
        push   <= 1'b1;
        x_code <= x;
        y_code <= y;
        last   <= lst;
        @(posedge clk);
        while (full)
            @(posedge clk);
        board.note_word(x, y, lst);
        words_in++;
        if (!steady)
        begin
            if (burst_left == 0)
            begin
                push <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
                burst_left = $urandom_range(0, 30);
            end
            else
                burst_left--;
        end
    endtask

    // Lowers push and waits until every expected result word has been popped.
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (board.fits_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(gfl_reg_t r, logic [15:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= {16'($urandom), v};   // upper bits are ignored by the block
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (r)
            REG_IN_MIN:  board.in_lo  = v;
            REG_IN_MAX:  board.in_hi  = v;
            REG_OUT_MIN: board.out_lo = v;
            default:     board.out_hi = v;
        endcase
        reg_writes++;
    endtask

    // Ranges change only with the block idle: every result is in, and the
    // divider and output stage have had time to settle.
    task automatic set_ranges(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                              logic [15:0] d);
        drain();
        repeat (150) @(posedge clk);
        write_reg(REG_IN_MIN, a);
        write_reg(REG_IN_MAX, b);
        write_reg(REG_OUT_MIN, c);
        write_reg(REG_OUT_MAX, d);
    endtask

    function automatic logic [15:0] pick_in(int lo, int hi);
        if (hi <= lo)
            return 16'($urandom);
        return 16'($urandom_range(lo, hi));
    endfunction

    // Random data sets, mostly well formed: x above its minimum, y at or
    // above its minimum. A minority are boundary codes or raw noise.
    task automatic random_sets(int n);
        int sent, len, kind;
        logic [15:0] x, y;
        sent = 0;
        while (sent < n)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
            begin
                kind = $urandom_range(0, 19);
                x = pick_in(board.in_lo + 1, board.in_hi);
                y = pick_in(board.out_lo + 1, board.out_hi);
                case (kind)
                    0: begin x = 16'($urandom); y = 16'($urandom); end
                    1: x = board.in_lo;
                    2: y = board.out_lo;
                    3: begin x = 16'hFFFF; y = 16'hFFFF; end
                    4: y = 16'($urandom);
                    5: x = board.in_hi;
                    default: ;
                endcase
                send_word(x, y, i == len - 1);
            end
            sent += len;
        end
    endtask

    initial
    begin
        board = new();
        board.clear_set();
        rst_n = 1'b0;
        push = 1'b0; pop = 1'b0; last = 1'b0;
        x_code = '0; y_code = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        words_in = 0; fits_out = 0; reg_writes = 0; idle_cycles = 0;
        burst_left = 0; steady = 0;
        hold_req = 0; hold_seen = 0; hold_left = 0;
        pop_pattern = 16'hFFFF; pop_phase = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset ranges: input at its minimum, unit and zero logs, output at its
        // minimum, a positive saturating fit, and a set with a zero denominator.
        send_word(16'd0, 16'd77, 1'b0);
        send_word(16'hFFFF, 16'hFFFF, 1'b0);
        send_word(16'd1, 16'd1, 1'b0);
        send_word(16'd1, 16'd0, 1'b0);
        send_word(16'h8000, 16'hFFFF, 1'b1);
        send_word(16'd65000, 16'd1, 1'b1);
        send_word(16'hFFFF, 16'd5, 1'b1);
        send_word(16'd0, 16'd0, 1'b1);

        // Offset ranges: samples below their minimum, and y above its maximum.
        set_ranges(16'd100, 16'd40000, 16'd50, 16'd60000);
        send_word(16'd99, 16'd1000, 1'b1);
        send_word(16'd200, 16'd49, 1'b0);
        send_word(16'd300, 16'd51, 1'b1);
        send_word(16'd101, 16'hFFFF, 1'b1);

        // Tiny output range gives a negative saturating fit.
        set_ranges(16'd0, 16'hFFFF, 16'd0, 16'd1);
        send_word(16'd65000, 16'hFFFF, 1'b1);
        send_word(16'd2, 16'd1, 1'b1);

        // Bad ranges: max equal to min, then max below min; then a one-code input range.
        set_ranges(16'h1234, 16'h1234, 16'd0, 16'hFFFF);
        send_word(16'h2000, 16'h2000, 1'b1);
        set_ranges(16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
        send_word(16'h2000, 16'h2000, 1'b0);
        send_word(16'hFFFF, 16'hFFFF, 1'b1);
        set_ranges(16'hFFFE, 16'hFFFF, 16'd0, 16'hFFFF);
        send_word(16'hFFFF, 16'd3, 1'b1);

        // Random phases, each under its own ranges; a few are extreme.
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: set_ranges(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
                1: set_ranges(16'($urandom_range(0, 300)), 16'($urandom_range(1000, 65535)),
                              16'($urandom_range(0, 300)), 16'($urandom_range(1000, 65535)));
                2: set_ranges(16'd0, 16'd1, 16'd0, 16'd1);
                3: set_ranges(16'($urandom_range(0, 60000)), 16'($urandom_range(0, 65535)),
                              16'($urandom_range(0, 60000)), 16'($urandom_range(0, 65535)));
                default: set_ranges(16'($urandom_range(0, 2000)),
                                    16'($urandom_range(30000, 65535)),
                                    16'($urandom_range(0, 2000)),
                                    16'($urandom_range(30000, 65535)));
            endcase
            steady = (p == 4);
            random_sets(185);
            if (p == 1)
            begin
                // Long receiver hold-off while one-word sets keep coming, so
                // the result register and the input queue both fill up.
                hold_req++;
                for (int i = 0; i < 20; i++)
                    send_word(board.in_lo, 16'($urandom), 1'b1);
                drain();
            end
        end
        steady = 0;

        drain();
        repeat (150) @(posedge clk);
        $display("Sent %0d input words and checked %0d fits over %0d register writes,",
                 words_in, fits_out, reg_writes);
        $display("covering bad ranges, below-minimum samples, saturation and a long hold-off.");
        if (board.errors == 0 && board.fits_due.size() == 0)
            $display("gamma_fit_log_least_squares_test OK");
        else
            $display("gamma_fit_log_least_squares_test NOT OK");
        $finish;
    end

endmodule
